[hw/rtl/rsmc_pkg.sv]
// shared types and constants of the rom segment map cache
`default_nettype none

package rsmc_pkg;

  // field widths
  localparam int TagW     = 7;
  localparam int StampW   = 32;
  localparam int BankW    = 9;
  localparam int SlotW    = 6;
  localparam int OffsetW  = 16;
  localparam int FillW    = 17;
  localparam int RomSizeW = 24;
  localparam int CfgIdxW  = 1;

  // geometry of banks and segments
  localparam int unsigned SegBytes  = (1 << 16);
  localparam int unsigned BankBytes = (16 * 1024);
  localparam int SegShift  = $clog2(SegBytes);
  localparam int BankShift = $clog2(BankBytes);

  // request codes
  localparam logic FuncLookup = 1'b0;
  localparam logic FuncFlush  = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegRomSize  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegBootOvly = 1'b1;

  // result codes
  typedef enum logic [2:0] {
    OUT_HIT    = 3'd0,
    OUT_FILL   = 3'd1,
    OUT_BOOT   = 3'd2,
    OUT_NOFILE = 3'd3,
    OUT_FLUSH  = 3'd4
  } outcome_e;

  // controls from the sequencer to the scan unit
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

  // summary of one scan over all slots
  typedef struct packed {
    logic              hit;
    logic [StampW-1:0] min_stamp;
    logic [TagW-1:0]   victim_tag;
  } scan_res_t;

endpackage

`default_nettype wire

[hw/rtl/rom_segment_map_cache_lru.sv]
// top level: fully associative rom segment map with lru replacement
`default_nettype none

// Maps 16 KiB rom banks onto 64 KiB segments held in SLOTS slots. Tag and
// use stamp of every slot live in one ram with a registered read; per-slot
// valid flops stand for the empty state after reset or a flush. A lookup
// makes one pass over the ram, reading one slot per cycle, and finds both
// the first tag hit and the least recently used slot in that pass, then
// writes the chosen slot back. A flush or a boot overlay hit of bank zero
// skips the pass and has its result known at the transfer. Each result
// waits in a pending register, and the input is freed once it has moved
// to the output register. One request is worked on at a time; the next
// one is taken while the previous result still waits in the output
// register. No clearing pass is needed.
module rom_segment_map_cache_lru #(
  parameter int SLOTS = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [rsmc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [rsmc_pkg::RomSizeW-1:0]     cfg_wdata_i,
  // request channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              func_i,
  input  wire logic [rsmc_pkg::BankW-1:0]        bank_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [2:0]                        outcome_o,
  output logic      [rsmc_pkg::SlotW-1:0]        slot_o,
  output logic      [rsmc_pkg::TagW-1:0]         segment_o,
  output logic      [rsmc_pkg::OffsetW-1:0]      offset_o,
  output logic                                   evict_valid_o,
  output logic      [rsmc_pkg::TagW-1:0]         evicted_segment_o,
  output logic      [rsmc_pkg::FillW-1:0]        fill_length_o
);

  localparam int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW  = $clog2(SLOTS + 1);
  localparam int MemW  = rsmc_pkg::TagW + rsmc_pkg::StampW;
  localparam int DiffW = rsmc_pkg::RomSizeW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    rsmc_pkg::outcome_e            outcome;
    logic [rsmc_pkg::SlotW-1:0]    slot;
    logic [rsmc_pkg::TagW-1:0]     segment;
    logic [rsmc_pkg::OffsetW-1:0]  offset;
    logic                          evict_valid;
    logic [rsmc_pkg::TagW-1:0]     evicted_segment;
    logic [rsmc_pkg::FillW-1:0]    fill_length;
  } res_t;

  state_e                          state_q;
  logic [rsmc_pkg::RomSizeW-1:0]   rom_size_q;
  logic                            boot_q;
  logic [rsmc_pkg::StampW-1:0]     ctr_q;
  logic [rsmc_pkg::StampW-1:0]     ctr_nxt;
  logic [SLOTS-1:0]                slot_vld_q;
  logic [CntW-1:0]                 cnt_q;
  logic                            rd_pend_q;
  logic [IdxW-1:0]                 rd_idx_q;
  logic                            vld_rd_q;
  logic                            out_valid_q;
  logic                            out_load;
  res_t                            pend_q;
  res_t                            out_q;
  res_t                            upd_res;
  res_t                            idle_res;

  // request registers
  logic [rsmc_pkg::TagW-1:0]       seg_q;
  logic [rsmc_pkg::OffsetW-1:0]    off_q;
  logic                            fits_q;
  logic [rsmc_pkg::FillW-1:0]      fill_q;

  logic                            in_xfer;
  logic [rsmc_pkg::TagW-1:0]       seg_in;
  logic [rsmc_pkg::OffsetW-1:0]    off_in;
  logic [DiffW-1:0]                diff;
  logic                            fits_in;
  logic [rsmc_pkg::FillW-1:0]      fill_in;

  logic                            rd_issue;
  logic [IdxW-1:0]                 rd_addr;
  logic [MemW-1:0]                 rd_data;
  logic [rsmc_pkg::StampW-1:0]     rd_stamp;
  logic                            mem_we;
  logic [IdxW-1:0]                 mem_waddr;
  logic [MemW-1:0]                 mem_wdata;

  rsmc_pkg::scan_ctl_t             scan_ctl;
  rsmc_pkg::scan_res_t             scan_res;
  logic [IdxW-1:0]                 hit_idx;
  logic [IdxW-1:0]                 victim_idx;

  // handshake
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_load    = (state_q == ST_RESULT) && (!out_valid_q || !out_stall_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_size_q <= '0;
      boot_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rsmc_pkg::RegRomSize:  rom_size_q <= cfg_wdata_i;
        rsmc_pkg::RegBootOvly: boot_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // bank split and fill length, clipped to one segment and the rom size
  assign seg_in  = rsmc_pkg::TagW'(bank_i >> (rsmc_pkg::SegShift - rsmc_pkg::BankShift));
  assign off_in  = rsmc_pkg::OffsetW'(bank_i[1:0]) << rsmc_pkg::BankShift;
  assign diff    = {1'b0, rom_size_q} - (DiffW'(seg_in) << rsmc_pkg::SegShift);
  assign fits_in = !diff[DiffW-1] && (diff != '0);
  assign fill_in = (diff > DiffW'(rsmc_pkg::SegBytes)) ?
                   rsmc_pkg::FillW'(rsmc_pkg::SegBytes) : diff[rsmc_pkg::FillW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      seg_q  <= seg_in;
      off_q  <= off_in;
      fits_q <= fits_in;
      fill_q <= fill_in;
    end
  end

  // slot read stream
  assign rd_issue = (state_q == ST_SCAN) && (cnt_q < CntW'(SLOTS));
  assign rd_addr  = cnt_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_addr;
    vld_rd_q <= slot_vld_q[rd_addr];
  end

  // an empty slot reads as stamp zero
  assign rd_stamp = vld_rd_q ? rd_data[rsmc_pkg::StampW-1:0] : '0;

  rsmc_ram #(
    .Width (MemW),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (rd_issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign scan_ctl.clear  = in_xfer;
  assign scan_ctl.sample = rd_pend_q;

  rsmc_scan #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (scan_ctl),
    .rd_idx_i     (rd_idx_q),
    .tag_i        (rd_data[MemW-1:rsmc_pkg::StampW]),
    .stamp_i      (rd_stamp),
    .seg_i        (seg_q),
    .res_o        (scan_res),
    .hit_idx_o    (hit_idx),
    .victim_idx_o (victim_idx)
  );

  // write back of the hit or refilled slot
  assign ctr_nxt   = ctr_q + 32'd1;
  assign mem_we    = (state_q == ST_UPDATE) && (scan_res.hit || fits_q);
  assign mem_waddr = scan_res.hit ? hit_idx : victim_idx;
  assign mem_wdata = {seg_q, ctr_nxt};

  // result of a flush or a boot overlay hit, known at the transfer
  always_comb begin
    idle_res = '0;
    if (func_i == rsmc_pkg::FuncFlush) begin
      idle_res.outcome = rsmc_pkg::OUT_FLUSH;
    end else begin
      idle_res.outcome = rsmc_pkg::OUT_BOOT;
      idle_res.segment = seg_in;
      idle_res.offset  = off_in;
    end
  end

  // result of a lookup after the scan
  always_comb begin
    upd_res                 = '0;
    upd_res.segment         = seg_q;
    upd_res.offset          = off_q;
    priority if (scan_res.hit) begin
      upd_res.outcome = rsmc_pkg::OUT_HIT;
      upd_res.slot    = rsmc_pkg::SlotW'(hit_idx);
    end else if (!fits_q) begin
      upd_res.outcome = rsmc_pkg::OUT_NOFILE;
    end else begin
      upd_res.outcome     = rsmc_pkg::OUT_FILL;
      upd_res.slot        = rsmc_pkg::SlotW'(victim_idx);
      upd_res.fill_length = fill_q;
      if (scan_res.min_stamp != '0) begin
        upd_res.evict_valid     = 1'b1;
        upd_res.evicted_segment = scan_res.victim_tag;
      end
    end
  end

  // sequencer, slot valid flags, use counter and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ctr_q       <= '0;
      slot_vld_q  <= '0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      pend_q      <= '0;
      out_q       <= '0;
    end else begin
      rd_pend_q <= rd_issue;
      if (out_load) begin
        out_q       <= pend_q;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            cnt_q <= '0;
            priority if (func_i == rsmc_pkg::FuncFlush) begin
              slot_vld_q <= '0;
              pend_q     <= idle_res;
              state_q    <= ST_RESULT;
            end else if (boot_q && (bank_i == '0)) begin
              pend_q     <= idle_res;
              state_q    <= ST_RESULT;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_issue) begin
            cnt_q <= cnt_q + CntW'(1);
          end else if (!rd_pend_q) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          pend_q <= upd_res;
          if (mem_we) begin
            slot_vld_q[mem_waddr] <= 1'b1;
            ctr_q                 <= ctr_nxt;
          end
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // result ports
  assign outcome_o         = out_q.outcome;
  assign slot_o            = out_q.slot;
  assign segment_o         = out_q.segment;
  assign offset_o          = out_q.offset;
  assign evict_valid_o     = out_q.evict_valid;
  assign evicted_segment_o = out_q.evicted_segment;
  assign fill_length_o     = out_q.fill_length;

`ifndef SYNTHESIS
  // the use counter only ever advances by one
  a_ctr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctr_q != $past(ctr_q)) |-> (ctr_q == $past(ctr_q) + 32'd1))
    else $error("use counter jumped");

  // a flush leaves every slot empty
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (func_i == rsmc_pkg::FuncFlush)) |=> (slot_vld_q == '0))
    else $error("flush left a slot valid");

  // a result appears only out of the result state
  a_out_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESULT))
    else $error("result shown outside result state");

  // eviction and fill length belong to fills alone
  a_fill_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.outcome != rsmc_pkg::OUT_FILL)) |->
    (!out_q.evict_valid && (out_q.fill_length == '0)))
    else $error("fill fields set on a non-fill result");

  // the ram is written only while the slot scan is idle
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (!rd_issue && !rd_pend_q))
    else $error("slot write overlaps the scan");
`endif

endmodule

`default_nettype wire

[hw/rtl/rsmc_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module rsmc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic      [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rsmc_scan.sv]
// scan unit: first tag hit and least recently used slot over a slot stream
`default_nettype none

module rsmc_scan #(
  parameter int SLOTS = 64
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire rsmc_pkg::scan_ctl_t                      ctl_i,
  input  wire logic [$clog2(SLOTS > 1 ? SLOTS : 2)-1:0] rd_idx_i,
  input  wire logic [rsmc_pkg::TagW-1:0]                tag_i,
  input  wire logic [rsmc_pkg::StampW-1:0]              stamp_i,
  input  wire logic [rsmc_pkg::TagW-1:0]                seg_i,
  output rsmc_pkg::scan_res_t                           res_o,
  output logic      [$clog2(SLOTS > 1 ? SLOTS : 2)-1:0] hit_idx_o,
  output logic      [$clog2(SLOTS > 1 ? SLOTS : 2)-1:0] victim_idx_o
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic                          first_q;
  logic                          hit_q;
  logic [IdxW-1:0]               hit_idx_q;
  logic [IdxW-1:0]               victim_idx_q;
  logic [rsmc_pkg::StampW-1:0]   min_q;
  logic [rsmc_pkg::TagW-1:0]     vtag_q;
  logic                          is_hit;
  logic                          is_min;

  // a used slot with the wanted tag, and a strictly smaller stamp
  assign is_hit = (stamp_i != '0) && (tag_i == seg_i) && !hit_q;
  assign is_min = first_q || (stamp_i < min_q);

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      hit_q   <= 1'b0;
    end else if (ctl_i.clear) begin
      first_q <= 1'b1;
      hit_q   <= 1'b0;
    end else if (ctl_i.sample) begin
      first_q <= 1'b0;
      if (is_hit) begin
        hit_q <= 1'b1;
      end
    end
  end

  // running hit index and minimum
  always_ff @(posedge clk_i) begin
    if (ctl_i.sample && !ctl_i.clear) begin
      if (is_hit) begin
        hit_idx_q <= rd_idx_i;
      end
      if (is_min) begin
        min_q        <= stamp_i;
        victim_idx_q <= rd_idx_i;
        vtag_q       <= tag_i;
      end
    end
  end

  assign res_o.hit        = hit_q;
  assign res_o.min_stamp  = min_q;
  assign res_o.victim_tag = vtag_q;
  assign hit_idx_o        = hit_idx_q;
  assign victim_idx_o     = victim_idx_q;

endmodule

`default_nettype wire
